// ===== src/ncsd_pkg.sv =====
// shared widths, codes and controller/datapath handshake types
`timescale 1ns / 1ps
package ncsd_pkg;

	localparam int FEATURE_W  = 12;
	localparam int CLUSTER_W  = 4;
	localparam int VALUE_W    = 16;
	localparam int SCORE_W    = 40;
	localparam int TIE_W      = 5;
	localparam int NCLUS_W    = 5;
	localparam int NFEAT_W    = 13;
	localparam int CFG_DATA_W = 13;
	localparam int PROD_W     = 2 * VALUE_W;

	localparam int DEF_MAX_CLUSTERS = 16;
	localparam int DEF_MAX_FEATURES = 4096;

	localparam logic [NCLUS_W-1:0] NCLUS_RESET = NCLUS_W'(16);
	localparam logic [NFEAT_W-1:0] NFEAT_RESET = NFEAT_W'(4096);

	localparam logic [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
	localparam logic [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};
	localparam logic [TIE_W-1:0]   TIE_SAT   = {TIE_W{1'b1}};

	localparam logic ACTION_LOAD    = 1'b0;
	localparam logic ACTION_FEATURE = 1'b1;

	typedef enum logic [0:0] {
		CFG_NUM_CLUSTERS = 1'b0,
		CFG_NUM_FEATURES = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic accept;
		logic mac_issue;
		logic scan_issue;
		logic emit;
	} ncsd_cmd_t;

	typedef struct packed {
		logic in_feature;
		logic in_counted;
		logic in_last;
		logic idx_end;
		logic busy;
		logic out_free;
	} ncsd_status_t;

endpackage

// ===== src/ncsd_item_if.sv =====
// input item channel
`timescale 1ns / 1ps
interface ncsd_item_if;
	import ncsd_pkg::*;

	logic                        valid;
	logic                        ready;
	logic                        action;
	logic [FEATURE_W-1:0]        feature_index;
	logic [CLUSTER_W-1:0]        cluster_index;
	logic signed [VALUE_W-1:0]   feature_value;
	logic                        last;

	modport source (output valid, action, feature_index, cluster_index, feature_value, last,
		input ready);
	modport sink (input valid, action, feature_index, cluster_index, feature_value, last,
		output ready);
endinterface

// ===== src/ncsd_result_if.sv =====
// result channel
`timescale 1ns / 1ps
interface ncsd_result_if;
	import ncsd_pkg::*;

	logic                        valid;
	logic                        ready;
	logic [CLUSTER_W-1:0]        nearest_cluster;
	logic signed [SCORE_W-1:0]   best_score;
	logic [TIE_W-1:0]            tie_count;

	modport source (output valid, nearest_cluster, best_score, tie_count, input ready);
	modport sink (input valid, nearest_cluster, best_score, tie_count, output ready);
endinterface

// ===== src/nearest_cluster_sparse_dot_unit.sv =====
// Nearest cluster by sparse inner product. A weight load (action 0) is taken while idle
// and written straight into the weight store. For a feature whose index is below
// num_features_in_use, one shared 16x16 multiplier walks the clusters one per cycle,
// reading weight and accumulator memories and writing the saturated sum back through
// stages s1 and s2. A feature at or beyond the limit leaves the accumulators untouched.
// A last feature then starts the argmax scan over the accumulator memory and the
// loading of the result register; the accumulators are then cleared at once through
// per-entry valid bits, so there is no clearing pass after reset. The result register
// lets the next items be taken while a result waits on its channel. The user must write
// configuration only while the block is idle; the block itself does not enforce it.
`timescale 1ns / 1ps
module nearest_cluster_sparse_dot_unit #(
	parameter int MAX_CLUSTERS = ncsd_pkg::DEF_MAX_CLUSTERS,
	parameter int MAX_FEATURES = ncsd_pkg::DEF_MAX_FEATURES
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  ncsd_pkg::cfg_idx_t              wr_index,
	input  logic [ncsd_pkg::CFG_DATA_W-1:0] wr_data,
	ncsd_item_if.sink                       item,
	ncsd_result_if.source                   result
);
	import ncsd_pkg::*;

	localparam int CW = $clog2(MAX_CLUSTERS);

	ncsd_cmd_t     cmd;
	ncsd_status_t  st;
	logic [CW-1:0] idx;

	ncsd_ctrl #(
		.MAX_CLUSTERS(MAX_CLUSTERS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item.ready),
		.cmd        (cmd),
		.idx        (idx),
		.st         (st)
	);

	ncsd_datapath #(
		.MAX_CLUSTERS(MAX_CLUSTERS),
		.MAX_FEATURES(MAX_FEATURES)
	) u_datapath (
		.clk                 (clk),
		.arst_n              (arst_n),
		.wr_en               (wr_en),
		.wr_index            (wr_index),
		.wr_data             (wr_data),
		.cmd                 (cmd),
		.idx                 (idx),
		.st                  (st),
		.in_action           (item.action),
		.in_feature_index    (item.feature_index),
		.in_cluster_index    (item.cluster_index),
		.in_feature_value    (item.feature_value),
		.in_last             (item.last),
		.res_valid           (result.valid),
		.res_ready           (result.ready),
		.res_nearest_cluster (result.nearest_cluster),
		.res_best_score      (result.best_score),
		.res_tie_count       (result.tie_count)
	);

endmodule

// ===== src/ncsd_datapath.sv =====
// weight store, accumulator memory, shared multiply-accumulate and argmax scan
`timescale 1ns / 1ps
module ncsd_datapath #(
	parameter int MAX_CLUSTERS = ncsd_pkg::DEF_MAX_CLUSTERS,
	parameter int MAX_FEATURES = ncsd_pkg::DEF_MAX_FEATURES
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    wr_en,
	input  ncsd_pkg::cfg_idx_t                      wr_index,
	input  logic [ncsd_pkg::CFG_DATA_W-1:0]         wr_data,
	input  ncsd_pkg::ncsd_cmd_t                     cmd,
	input  logic [$clog2(MAX_CLUSTERS)-1:0]         idx,
	output ncsd_pkg::ncsd_status_t                  st,
	input  logic                                    in_action,
	input  logic [ncsd_pkg::FEATURE_W-1:0]          in_feature_index,
	input  logic [ncsd_pkg::CLUSTER_W-1:0]          in_cluster_index,
	input  logic signed [ncsd_pkg::VALUE_W-1:0]     in_feature_value,
	input  logic                                    in_last,
	output logic                                    res_valid,
	input  logic                                    res_ready,
	output logic [ncsd_pkg::CLUSTER_W-1:0]          res_nearest_cluster,
	output logic signed [ncsd_pkg::SCORE_W-1:0]     res_best_score,
	output logic [ncsd_pkg::TIE_W-1:0]              res_tie_count
);
	import ncsd_pkg::*;

	localparam int CW     = $clog2(MAX_CLUSTERS);
	localparam int FW     = $clog2(MAX_FEATURES);
	localparam int WDEPTH = 2 ** (FW + CW);

	// configuration
	logic [NCLUS_W-1:0] nclus_q;
	logic [NFEAT_W-1:0] nfeat_q;
	logic [NCLUS_W-1:0] nclus_nz;
	logic [NCLUS_W-1:0] nc_m1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nclus_q <= NCLUS_RESET;
			nfeat_q <= NFEAT_RESET;
		end else if (wr_en) begin
			case (wr_index)
				CFG_NUM_CLUSTERS: nclus_q <= wr_data[NCLUS_W-1:0];
				CFG_NUM_FEATURES: nfeat_q <= wr_data[NFEAT_W-1:0];
				default: ;
			endcase
		end
	end

	// zero clusters acts as one, too many clamps to the store size
	always_comb begin
		nclus_nz = (nclus_q == '0) ? NCLUS_W'(1) : nclus_q;
		if (32'(nclus_nz) > 32'(MAX_CLUSTERS))
			nc_m1 = NCLUS_W'(MAX_CLUSTERS - 1);
		else
			nc_m1 = nclus_nz - NCLUS_W'(1);
	end

	// captured item
	logic [FW-1:0]              feat_q;
	logic signed [VALUE_W-1:0]  val_q;

	// memories
	logic signed [VALUE_W-1:0]  wmem [WDEPTH];
	logic signed [SCORE_W-1:0]  amem [MAX_CLUSTERS];
	logic [MAX_CLUSTERS-1:0]    avld_q;

	logic                       load_ok;

	assign load_ok = cmd.accept && (in_action == ACTION_LOAD)
		&& (32'(in_feature_index) < 32'(MAX_FEATURES))
		&& (32'(in_cluster_index) < 32'(MAX_CLUSTERS));

	// pipeline
	logic                       mac_s1, scan_s1, avld_s1;
	logic [CW-1:0]              idx_s1;
	logic signed [SCORE_W-1:0]  rd_s1;
	logic signed [VALUE_W-1:0]  w_s1;
	logic                       mac_s2;
	logic [CW-1:0]              idx_s2;
	logic signed [SCORE_W-1:0]  acc_s2;
	logic signed [PROD_W-1:0]   prod_s2;

	logic signed [SCORE_W-1:0]  acc_in;
	logic signed [SCORE_W:0]    sum_w;
	logic signed [SCORE_W-1:0]  sum_sat;

	// best-so-far of the scan
	logic signed [SCORE_W-1:0]  best_score_q;
	logic [CW-1:0]              best_idx_q;
	logic [TIE_W-1:0]           ties_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			feat_q <= FW'(in_feature_index);
			val_q  <= in_feature_value;
		end
		if (load_ok)
			wmem[{FW'(in_feature_index), CW'(in_cluster_index)}] <= in_feature_value;
		if (cmd.mac_issue || cmd.scan_issue)
			rd_s1 <= amem[idx];
		if (cmd.mac_issue)
			w_s1 <= wmem[{feat_q, idx}];
		if (mac_s2)
			amem[idx_s2] <= sum_sat;
	end

	always_ff @(posedge clk) begin
		avld_s1 <= avld_q[idx];
		idx_s1  <= idx;
		idx_s2  <= idx_s1;
		acc_s2  <= acc_in;
		prod_s2 <= val_q * w_s1;
	end

	assign acc_in = avld_s1 ? rd_s1 : '0;

	always_comb begin
		sum_w = {acc_s2[SCORE_W-1], acc_s2}
			+ {{(SCORE_W+1-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
		if (sum_w[SCORE_W] != sum_w[SCORE_W-1])
			sum_sat = sum_w[SCORE_W] ? SCORE_MIN : SCORE_MAX;
		else
			sum_sat = sum_w[SCORE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_s1  <= 1'b0;
			scan_s1 <= 1'b0;
			mac_s2  <= 1'b0;
			avld_q  <= '0;
		end else begin
			mac_s1  <= cmd.mac_issue;
			scan_s1 <= cmd.scan_issue;
			mac_s2  <= mac_s1;
			if (cmd.emit)
				avld_q <= '0;
			else if (mac_s2)
				avld_q[idx_s2] <= 1'b1;
		end
	end

	// argmax, first cluster seeds the running best
	always_ff @(posedge clk) begin
		if (scan_s1) begin
			if (idx_s1 == '0) begin
				best_score_q <= acc_in;
				best_idx_q   <= '0;
				ties_q       <= TIE_W'(1);
			end else if (acc_in > best_score_q) begin
				best_score_q <= acc_in;
				best_idx_q   <= idx_s1;
				ties_q       <= TIE_W'(1);
			end else if (acc_in == best_score_q && ties_q != TIE_SAT) begin
				ties_q <= ties_q + TIE_W'(1);
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid <= 1'b0;
		else if (cmd.emit)
			res_valid <= 1'b1;
		else if (res_ready)
			res_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_nearest_cluster <= CLUSTER_W'(best_idx_q);
			res_best_score      <= best_score_q;
			res_tie_count       <= ties_q;
		end
	end

	always_comb begin
		st.in_feature = (in_action == ACTION_FEATURE);
		st.in_counted = (32'(in_feature_index) < 32'(nfeat_q))
			&& (32'(in_feature_index) < 32'(MAX_FEATURES));
		st.in_last    = in_last;
		st.idx_end    = (32'(idx) == 32'(nc_m1));
		st.busy       = mac_s1 || mac_s2 || scan_s1;
		st.out_free   = !res_valid || res_ready;
	end

endmodule

// ===== src/ncsd_ctrl.sv =====
// sequencer: per-cluster issue loop for scoring and for the argmax scan
`timescale 1ns / 1ps
module ncsd_ctrl #(
	parameter int MAX_CLUSTERS = ncsd_pkg::DEF_MAX_CLUSTERS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_ready,
	output ncsd_pkg::ncsd_cmd_t             cmd,
	output logic [$clog2(MAX_CLUSTERS)-1:0] idx,
	input  ncsd_pkg::ncsd_status_t          st
);
	import ncsd_pkg::*;

	localparam int CW = $clog2(MAX_CLUSTERS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MAC,
		S_MAC_DRAIN,
		S_SCAN,
		S_SCAN_DRAIN,
		S_EMIT
	} state_t;

	state_t        state_q;
	logic [CW-1:0] idx_q;
	logic          last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			last_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (item_valid && st.in_feature) begin
						last_q <= st.in_last;
						idx_q  <= '0;
						if (st.in_counted)
							state_q <= S_MAC;
						else if (st.in_last)
							state_q <= S_SCAN;
					end
				end
				S_MAC: begin
					if (st.idx_end) begin
						idx_q   <= '0;
						state_q <= S_MAC_DRAIN;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				S_MAC_DRAIN: begin
					if (!st.busy)
						state_q <= last_q ? S_SCAN : S_IDLE;
				end
				S_SCAN: begin
					if (st.idx_end)
						state_q <= S_SCAN_DRAIN;
					else
						idx_q <= idx_q + CW'(1);
				end
				S_SCAN_DRAIN: begin
					if (!st.busy)
						state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (st.out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign item_ready = (state_q == S_IDLE);
	assign idx        = idx_q;

	always_comb begin
		cmd.accept     = item_valid && (state_q == S_IDLE);
		cmd.mac_issue  = (state_q == S_MAC);
		cmd.scan_issue = (state_q == S_SCAN);
		cmd.emit       = (state_q == S_EMIT) && st.out_free;
	end

endmodule

// ===== src/ncsd_checker.sv =====
// port-level checks for the top level, attached by bind
`timescale 1ns / 1ps
module ncsd_checker (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input logic item_ready,
	input logic item_action,
	input logic item_last,
	input logic result_valid,
	input logic result_ready,
	input logic [ncsd_pkg::TIE_W-1:0] result_tie_count
);
	import ncsd_pkg::*;

	// a pending result transaction is not withdrawn
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result valid dropped while stalled");

	// at least the winning cluster ties with itself
	a_ties_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result_tie_count != '0)
		else $error("tie count of zero");

	// a closing feature leads into the argmax scan, so no item follows at once
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item_action == ACTION_FEATURE && item_last
		|=> !item_ready)
		else $error("item taken right after a closing feature");

	// weight loads do not hold the input
	a_load_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item_action == ACTION_LOAD |=> item_ready)
		else $error("weight load held the input");

endmodule

bind nearest_cluster_sparse_dot_unit ncsd_checker u_ncsd_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.item_valid       (item.valid),
	.item_ready       (item.ready),
	.item_action      (item.action),
	.item_last        (item.last),
	.result_valid     (result.valid),
	.result_ready     (result.ready),
	.result_tie_count (result.tie_count)
);

// ===== tb/ncsd_score_checker.sv =====
// checker that predicts nearest-cluster results from the item stream and compares them
`timescale 1ns / 1ps
module ncsd_score_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  ncsd_pkg::cfg_idx_t              wr_index,
	input  logic [ncsd_pkg::CFG_DATA_W-1:0] wr_data,
	ncsd_item_if                            item,
	ncsd_result_if                          result,
	output int                              mismatches,
	output int                              outstanding
);
	import ncsd_pkg::*;

	typedef struct {
		logic [CLUSTER_W-1:0]      cluster;
		logic signed [SCORE_W-1:0] score;
		logic [TIE_W-1:0]          ties;
	} nearest_t;

	localparam longint SCORE_HI = 64'sd549755813887;
	localparam longint SCORE_LO = -SCORE_HI - 1;

	logic signed [VALUE_W-1:0] weights [0:DEF_MAX_FEATURES*DEF_MAX_CLUSTERS-1];
	longint                    scores [0:DEF_MAX_CLUSTERS-1];
	logic [NCLUS_W-1:0]        clusters_cfg;
	logic [NFEAT_W-1:0]        features_cfg;
	nearest_t                  nearest_q [$];

	always @(posedge clk or negedge arst_n) begin : watch
		nearest_t want;
		longint   sum;
		longint   best;
		int       used;
		int       k;
		if (!arst_n) begin
			clusters_cfg = NCLUS_RESET;
			features_cfg = NFEAT_RESET;
			for (k = 0; k < DEF_MAX_CLUSTERS; k++)
				scores[k] = 0;
			nearest_q.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					CFG_NUM_CLUSTERS: clusters_cfg = wr_data[NCLUS_W-1:0];
					CFG_NUM_FEATURES: features_cfg = wr_data[NFEAT_W-1:0];
					default: ;
				endcase
			end

			// a result leaving now was predicted at an earlier edge
			if (result.valid && result.ready) begin
				if (nearest_q.size() == 0) begin
					$error("unexpected result: nearest_cluster %0d best_score %0d tie_count %0d",
						result.nearest_cluster, result.best_score, result.tie_count);
					mismatches++;
				end else begin
					want = nearest_q.pop_front();
					if (result.nearest_cluster !== want.cluster) begin
						$error("nearest_cluster: expected %0d, actual %0d",
							want.cluster, result.nearest_cluster);
						mismatches++;
					end
					if (result.best_score !== want.score) begin
						$error("best_score: expected %0d, actual %0d",
							want.score, result.best_score);
						mismatches++;
					end
					if (result.tie_count !== want.ties) begin
						$error("tie_count: expected %0d, actual %0d",
							want.ties, result.tie_count);
						mismatches++;
					end
				end
			end

			if (item.valid && item.ready) begin
				if (item.action == ACTION_LOAD) begin
					weights[{item.feature_index, item.cluster_index}] = item.feature_value;
				end else begin
					used = (clusters_cfg == 0) ? 1 :
						(clusters_cfg > DEF_MAX_CLUSTERS) ? DEF_MAX_CLUSTERS : int'(clusters_cfg);
					if (item.feature_index < features_cfg) begin
						for (k = 0; k < used; k++) begin
							sum = scores[k] + longint'(item.feature_value) *
								longint'(weights[{item.feature_index, CLUSTER_W'(k)}]);
							if (sum > SCORE_HI)
								sum = SCORE_HI;
							else if (sum < SCORE_LO)
								sum = SCORE_LO;
							scores[k] = sum;
						end
					end
					if (item.last) begin
						// lowest index wins, exact ties counted
						best = scores[0];
						want.cluster = '0;
						want.ties = TIE_W'(1);
						for (k = 1; k < used; k++) begin
							if (scores[k] > best) begin
								best = scores[k];
								want.cluster = CLUSTER_W'(k);
								want.ties = TIE_W'(1);
							end else if (scores[k] == best) begin
								want.ties = want.ties + 1'b1;
							end
						end
						want.score = SCORE_W'(best);
						nearest_q = {nearest_q, want};
						for (k = 0; k < DEF_MAX_CLUSTERS; k++)
							scores[k] = 0;
					end
				end
			end
			outstanding = nearest_q.size();
		end
	end
endmodule

// ===== tb/tb_nearest_cluster_sparse_dot_unit.sv =====
// testbench top: weight loads, sparse data, config phases and the pass/fail verdict
`timescale 1ns / 1ps
module tb_nearest_cluster_sparse_dot_unit;
	import ncsd_pkg::*;

	typedef enum int {
		W_RANDOM,
		W_FLAT,
		W_FEW,
		W_MIXED,
		W_SPIKE,
		W_UNITY,
		W_SATURATE
	} weight_style_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  wr_en = 1'b0;
	cfg_idx_t              wr_index = CFG_NUM_CLUSTERS;
	logic [CFG_DATA_W-1:0] wr_data = '0;
	int                    mismatches;
	int                    outstanding;

	logic [NFEAT_W-1:0]    cur_nf;
	bit                    loaded [0:DEF_MAX_FEATURES-1];
	int                    pool [$];
	int                    burst_left = 0;
	int                    items_sent = 0;
	bit                    hold_off = 1'b0;

	ncsd_item_if   item_ch ();
	ncsd_result_if result_ch ();

	nearest_cluster_sparse_dot_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.item     (item_ch),
		.result   (result_ch)
	);

	ncsd_score_checker score_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.item        (item_ch),
		.result      (result_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always #10 clk = ~clk;

	// one item transaction, with bursts and gaps on the sending side
	task automatic send(input logic act, input logic [FEATURE_W-1:0] f,
		input logic [CLUSTER_W-1:0] c, input logic [VALUE_W-1:0] v, input logic lst);
		if (burst_left == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 250) :
				$urandom_range(1, 16);
		end
		item_ch.valid <= 1'b1;
		item_ch.action <= act;
		item_ch.feature_index <= f;
		item_ch.cluster_index <= c;
		item_ch.feature_value <= v;
		item_ch.last <= lst;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		@(negedge clk);
		burst_left--;
		items_sent++;
	endtask

	task automatic drain();
		item_ch.valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		// covers a trailing feature still in the multiply pipe
		repeat (48) @(negedge clk);
	endtask

	task automatic wr_cfg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] d);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= d;
		@(negedge clk);
		wr_en <= 1'b0;
		@(negedge clk);
		if (idx == CFG_NUM_FEATURES)
			cur_nf = d;
	endtask

	function automatic logic [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0, 1, 2: return VALUE_W'($urandom);
			3, 4: begin
				case ($urandom_range(0, 4))
					0: return 16'h8000;
					1: return 16'h7FFF;
					2: return 16'h0000;
					3: return 16'h0001;
					default: return 16'hFFFF;
				endcase
			end
			5, 6, 7: return VALUE_W'($urandom_range(0, 8) - 4);
			default: return $urandom_range(0, 1) ? 16'h4000 : 16'hC000;
		endcase
	endfunction

	// writes all sixteen cluster weights of one feature
	task automatic load_feature(input int f, input weight_style_t style);
		logic [VALUE_W-1:0] few [3];
		logic [VALUE_W-1:0] w;
		int                 k;
		for (k = 0; k < 3; k++)
			few[k] = pick_value();
		for (k = 0; k < DEF_MAX_CLUSTERS; k++) begin
			case (style)
				W_RANDOM: w = VALUE_W'($urandom);
				W_FLAT: w = few[0];
				W_FEW: w = few[$urandom_range(0, 2)];
				W_MIXED: w = pick_value();
				W_SPIKE: w = (k == 9) ? 16'h7FFF : 16'h8000;
				W_UNITY: w = 16'h4000;
				default: w = (k == 0) ? 16'h8000 : (k == 1) ? 16'h7FFF : VALUE_W'($urandom);
			endcase
			send(ACTION_LOAD, FEATURE_W'(f), CLUSTER_W'(k), w, 1'($urandom));
		end
		if (!loaded[f])
			pool = {pool, f};
		loaded[f] = 1'b1;
	endtask

	// one datum; a feature below the limit is only sent once its weights exist
	task automatic send_datum(input int len);
		int i;
		int f;
		int r;
		for (i = 0; i < len; i++) begin
			if ($urandom_range(0, 9) == 0)
				send(ACTION_LOAD, FEATURE_W'(pool[$urandom_range(0, pool.size() - 1)]),
					CLUSTER_W'($urandom), pick_value(), 1'($urandom));
			r = $urandom_range(0, 99);
			if (r < 12 && pool.size() < 48) begin
				if (cur_nf > 0 && $urandom_range(0, 1))
					f = $urandom_range(0, (cur_nf > DEF_MAX_FEATURES) ?
						DEF_MAX_FEATURES - 1 : cur_nf - 1);
				else
					f = $urandom_range(0, DEF_MAX_FEATURES - 1);
				if (f < cur_nf && !loaded[f])
					load_feature(f, weight_style_t'($urandom_range(0, 3)));
			end else if (r < 30 && cur_nf < DEF_MAX_FEATURES) begin
				f = $urandom_range(cur_nf, DEF_MAX_FEATURES - 1);
			end else begin
				f = pool[$urandom_range(0, pool.size() - 1)];
			end
			send(ACTION_FEATURE, FEATURE_W'(f), CLUSTER_W'($urandom), pick_value(),
				i == len - 1);
		end
	endtask

	// result side: stall patterns, plus one long hold-off on request
	initial begin
		int mode;
		int mode_left;
		int cyc;
		mode = 0;
		mode_left = 0;
		cyc = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off) begin
				hold_off = 1'b0;
				result_ch.ready <= 1'b0;
				repeat (400) @(negedge clk);
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(16, 200);
			end
			mode_left--;
			cyc++;
			case (mode)
				0: result_ch.ready <= 1'b1;
				1: result_ch.ready <= 1'($urandom_range(0, 1));
				2: result_ch.ready <= ($urandom_range(0, 3) == 0);
				default: result_ch.ready <= cyc[2];
			endcase
		end
	end

	initial begin
		int phase;
		int r;
		item_ch.valid = 1'b0;
		item_ch.action = ACTION_LOAD;
		item_ch.feature_index = '0;
		item_ch.cluster_index = '0;
		item_ch.feature_value = '0;
		item_ch.last = 1'b0;
		cur_nf = NFEAT_RESET;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: one standout cluster, a wide tie, all clusters tying
		load_feature(DEF_MAX_FEATURES - 1, W_SPIKE);
		load_feature(0, W_UNITY);
		send(ACTION_FEATURE, 12'hFFF, 4'h0, 16'h8000, 1'b1);
		send(ACTION_FEATURE, 12'h000, 4'hF, 16'h7FFF, 1'b0);
		send(ACTION_FEATURE, 12'hFFF, 4'h0, 16'h7FFF, 1'b1);
		send(ACTION_FEATURE, 12'h000, 4'h0, 16'h0001, 1'b1);

		// zero clusters acts as one; zero feature limit makes every datum empty
		drain();
		wr_cfg(CFG_NUM_CLUSTERS, 13'd0);
		wr_cfg(CFG_NUM_FEATURES, 13'd0);
		send(ACTION_FEATURE, 12'hFFF, 4'h5, 16'h7FFF, 1'b0);
		send(ACTION_FEATURE, 12'h000, 4'hA, 16'h8000, 1'b1);

		// oversized settings clamp to the full store
		drain();
		wr_cfg(CFG_NUM_CLUSTERS, 13'd31);
		wr_cfg(CFG_NUM_FEATURES, 13'd8191);
		send(ACTION_FEATURE, 12'h000, 4'h3, 16'hC000, 1'b0);
		send(ACTION_FEATURE, 12'hFFF, 4'hC, 16'h8000, 1'b1);

		// closing feature beyond the limit still ends the datum
		drain();
		wr_cfg(CFG_NUM_CLUSTERS, 13'd1);
		wr_cfg(CFG_NUM_FEATURES, 13'd1);
		send(ACTION_FEATURE, 12'h000, 4'h0, 16'h7FFF, 1'b0);
		send(ACTION_FEATURE, 12'hFFF, 4'h0, 16'h7FFF, 1'b1);

		// drive one accumulator past the top and another past the bottom
		drain();
		wr_cfg(CFG_NUM_CLUSTERS, 13'd2);
		wr_cfg(CFG_NUM_FEATURES, 13'd4096);
		load_feature(1, W_SATURATE);
		repeat (515) send(ACTION_FEATURE, 12'h001, CLUSTER_W'($urandom), 16'h8000, 1'b0);
		send(ACTION_FEATURE, 12'h001, CLUSTER_W'($urandom), 16'h7FFF, 1'b1);

		phase = 0;
		while (items_sent < 1150) begin
			drain();
			if ($urandom_range(0, 9) < 7) begin
				case ($urandom_range(0, 3))
					0: wr_cfg(CFG_NUM_CLUSTERS, 13'd16);
					1: wr_cfg(CFG_NUM_CLUSTERS, CFG_DATA_W'($urandom_range(1, 4)));
					2: wr_cfg(CFG_NUM_CLUSTERS, CFG_DATA_W'($urandom_range(0, 31)));
					default: wr_cfg(CFG_NUM_CLUSTERS, CFG_DATA_W'($urandom_range(5, 16)));
				endcase
			end
			if ($urandom_range(0, 9) < 7) begin
				r = $urandom_range(0, 99);
				if (r < 35)
					wr_cfg(CFG_NUM_FEATURES, 13'd4096);
				else if (r < 50)
					wr_cfg(CFG_NUM_FEATURES, CFG_DATA_W'($urandom_range(4097, 8191)));
				else if (r < 65)
					wr_cfg(CFG_NUM_FEATURES, CFG_DATA_W'($urandom_range(0, 16)));
				else
					wr_cfg(CFG_NUM_FEATURES, CFG_DATA_W'($urandom_range(0, 4096)));
			end
			// result side blocks while data keep coming, so the input backs up
			if (phase % 7 == 2)
				hold_off = 1'b1;
			repeat ($urandom_range(4, 14)) begin
				r = $urandom_range(0, 99);
				if (r < 80)
					send_datum($urandom_range(1, 6));
				else if (r < 95)
					send_datum($urandom_range(7, 20));
				else
					send_datum($urandom_range(21, 60));
			end
			phase++;
		end

		drain();
		if (mismatches == 0)
			$display("tb_nearest_cluster_sparse_dot_unit: done, clean");
		else
			$display("tb_nearest_cluster_sparse_dot_unit: done, errors");
		$finish;
	end

	initial begin
		#40000000;
		$display("tb_nearest_cluster_sparse_dot_unit: done, errors");
		$finish;
	end
endmodule
